// ===== sv/owtm_pkg.sv =====
`default_nettype none

package owtm_pkg;

    // Number of id bytes read by the read id command.
    localparam int ROM_BYTES     = 8;
    localparam int BYTE_IDX_W    = $clog2(ROM_BYTES);
    localparam int BITS_PER_BYTE = 8;
    localparam int TIMER_W       = 10;
    localparam int STEP_W        = 4;
    localparam int QUEUE_DEPTH   = 2;

    // Input command codes.
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RESET = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_TEMP  = 3'd4;
    localparam logic [2:0] OP_ROM   = 3'd5;

    // First program step of each command; zero means no command.
    localparam logic [STEP_W-1:0] STEP_NONE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_RESET = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WRITE = 4'd2;
    localparam logic [STEP_W-1:0] STEP_READ  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TEMP  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ROM   = 4'd12;

    // Bus command bytes.
    localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hbe;
    localparam logic [7:0] CMD_READ_ROM = 8'h33;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_RESET_RELEASE = 3'd1,
        REG_PRESENCE_WAIT = 3'd2,
        REG_READ_SAMPLE   = 3'd3,
        REG_READ_RECOVERY = 3'd4,
        REG_WRITE_LEAD    = 3'd5,
        REG_WRITE_SLOT    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [TIMER_W-1:0] reset_low_us;
        logic [TIMER_W-1:0] reset_release_us;
        logic [TIMER_W-1:0] presence_wait_us;
        logic [TIMER_W-1:0] read_sample_us;
        logic [TIMER_W-1:0] read_recovery_us;
        logic [TIMER_W-1:0] write_lead_us;
        logic [TIMER_W-1:0] write_slot_us;
    } cfg_t;

    // One classified tick as it travels from the front end to the sequencer.
    typedef struct packed {
        logic [STEP_W-1:0] start_step;
        logic [7:0]        write_byte;
        logic              line_level;
    } tick_item_t;

    typedef struct packed {
        logic [63:0]        rom_id;
        logic signed [14:0] temperature_centi;
        logic [7:0]         read_byte;
        logic               done_res;
        logic               busy_res;
        logic               drive_low;
    } result_t;

    // Bus primitive kinds of the sequence program.
    typedef enum logic [1:0] {
        K_RESET  = 2'd0,
        K_WFIX   = 2'd1,
        K_WLATCH = 2'd2,
        K_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_NONE = 2'd0,
        S_LOW  = 2'd1,
        S_TEMP = 2'd2,
        S_ROM  = 2'd3
    } store_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data;
        store_t            store;
        logic [STEP_W-1:0] next;
    } entry_t;

    // Sequence program: each step is one bus primitive and its successor.
    function automatic entry_t prog_entry(input logic [STEP_W-1:0] idx);
        entry_t e;
        e = '{kind: K_RESET, data: 8'h00, store: S_NONE, next: STEP_NONE};
        case (idx)
            4'd2:    e.kind = K_WLATCH;
            4'd3:    e.kind = K_READ;
            4'd4:    e.next = 4'd5;
            4'd5:    e = '{kind: K_WFIX, data: CMD_SKIP_ROM, store: S_NONE, next: 4'd6};
            4'd6:    e = '{kind: K_WFIX, data: CMD_CONVERT, store: S_NONE, next: 4'd7};
            4'd7:    e.next = 4'd8;
            4'd8:    e = '{kind: K_WFIX, data: CMD_SKIP_ROM, store: S_NONE, next: 4'd9};
            4'd9:    e = '{kind: K_WFIX, data: CMD_READ_PAD, store: S_NONE, next: 4'd10};
            4'd10:   e = '{kind: K_READ, data: 8'h00, store: S_LOW, next: 4'd11};
            4'd11:   e = '{kind: K_READ, data: 8'h00, store: S_TEMP, next: STEP_NONE};
            4'd12:   e.next = 4'd13;
            4'd13:   e = '{kind: K_WFIX, data: CMD_READ_ROM, store: S_NONE, next: 4'd14};
            4'd14:   e = '{kind: K_READ, data: 8'h00, store: S_ROM, next: STEP_NONE};
            default: e = '{kind: K_RESET, data: 8'h00, store: S_NONE, next: STEP_NONE};
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== sv/owtm_front.sv =====
`default_nettype none

module owtm_front (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [2:0]              in_op,
    input  wire  [7:0]              in_write_byte,
    input  wire                     in_line_level,
    output logic                    item_valid,
    input  wire                     item_ready,
    output owtm_pkg::tick_item_t    item
);

    logic                 valid_reg, valid_next;
    owtm_pkg::tick_item_t item_reg, item_next;
    logic [owtm_pkg::STEP_W-1:0] start_step;

    // Map the command code to the first program step; unknown codes are plain ticks.
    always_comb begin
        unique case (in_op)
            owtm_pkg::OP_RESET: start_step = owtm_pkg::STEP_RESET;
            owtm_pkg::OP_WRITE: start_step = owtm_pkg::STEP_WRITE;
            owtm_pkg::OP_READ:  start_step = owtm_pkg::STEP_READ;
            owtm_pkg::OP_TEMP:  start_step = owtm_pkg::STEP_TEMP;
            owtm_pkg::OP_ROM:   start_step = owtm_pkg::STEP_ROM;
            default:            start_step = owtm_pkg::STEP_NONE;
        endcase
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Hold one classified tick until the queue takes it.
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_valid && in_ready) begin
            valid_next           = 1'b1;
            item_next.start_step = start_step;
            item_next.write_byte = in_write_byte;
            item_next.line_level = in_line_level;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== sv/owtm_queue.sv =====
`default_nettype none

module owtm_queue (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     push,
    input  owtm_pkg::tick_item_t    push_item,
    output logic                    push_ready,
    input  wire                     pop,
    output logic                    pop_valid,
    output owtm_pkg::tick_item_t    pop_item
);

    localparam int PTR_W = $clog2(owtm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(owtm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(owtm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(owtm_pkg::QUEUE_DEPTH);

    owtm_pkg::tick_item_t slots_reg [owtm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill count above depth");

endmodule

`default_nettype wire

// ===== sv/owtm_back.sv =====
`default_nettype none

module owtm_back (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  owtm_pkg::cfg_t          cfg,
    input  wire                     item_valid,
    input  owtm_pkg::tick_item_t    item,
    output logic                    item_pop,
    output logic                    res_valid,
    input  wire                     res_ready,
    output owtm_pkg::result_t       res
);

    localparam int BW = owtm_pkg::BYTE_IDX_W;
    localparam logic [BW-1:0] LAST_BYTE = BW'(owtm_pkg::ROM_BYTES - 1);
    localparam logic [3:0]    BYTE_BITS = 4'(owtm_pkg::BITS_PER_BYTE);

    typedef enum logic [11:0] {
        PH_IDLE     = 12'b000000000001,
        PH_RST_LOW  = 12'b000000000010,
        PH_RST_REL  = 12'b000000000100,
        PH_RST_WAIT = 12'b000000001000,
        PH_RST_HIGH = 12'b000000010000,
        PH_WR_LEAD  = 12'b000000100000,
        PH_WR_START = 12'b000001000000,
        PH_WR_HOLD  = 12'b000010000000,
        PH_WR_REC   = 12'b000100000000,
        PH_RD_START = 12'b001000000000,
        PH_RD_WAIT  = 12'b010000000000,
        PH_RD_REC   = 12'b100000000000
    } phase_t;

    typedef struct packed {
        logic [owtm_pkg::STEP_W-1:0] step;
        phase_t                      phase;
        logic [7:0]                  shift;
    } seq_t;

    logic [owtm_pkg::STEP_W-1:0]  step_reg, step_next;
    phase_t                       phase_reg, phase_next;
    logic [owtm_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic [3:0]                   bit_reg, bit_next;
    logic [BW-1:0]                byte_reg, byte_next;
    logic [7:0]                   shift_reg, shift_next;
    logic [7:0]                   low_reg, low_next;
    logic [63:0]                  rom_reg, rom_next;
    logic signed [14:0]           temp_reg, temp_next;
    logic [7:0]                   last_reg, last_next;
    logic                         res_valid_reg, res_valid_next;
    owtm_pkg::result_t            res_reg, res_next;

    logic [owtm_pkg::TIMER_W-1:0] dur;
    logic [owtm_pkg::TIMER_W-1:0] timer_inc;
    logic                         timer_hit;
    logic                         finish;
    logic                         rom_again;
    logic                         drive;
    logic                         done;
    owtm_pkg::entry_t             cur_entry;
    seq_t                         entered;

    // Start a program step: set its phase and preload the shift register.
    function automatic seq_t enter_step(input logic [owtm_pkg::STEP_W-1:0] idx,
                                        input logic [7:0] shift_in);
        owtm_pkg::entry_t e;
        seq_t r;
        e       = owtm_pkg::prog_entry(idx);
        r.step  = idx;
        r.shift = shift_in;
        r.phase = PH_RST_LOW;
        unique case (e.kind)
            owtm_pkg::K_RESET:  r.phase = PH_RST_LOW;
            owtm_pkg::K_WFIX: begin
                r.shift = e.data;
                r.phase = PH_WR_LEAD;
            end
            owtm_pkg::K_WLATCH: r.phase = PH_WR_LEAD;
            owtm_pkg::K_READ: begin
                r.shift = 8'h00;
                r.phase = PH_RD_START;
            end
        endcase
        return r;
    endfunction

    // Raw 1/16 degree reading to hundredths: raw*6 + raw/4, saturated to 15 bits.
    function automatic logic signed [14:0] to_centi(input logic [7:0] lo, input logic [7:0] hi);
        logic signed [15:0] raw;
        logic signed [18:0] wide;
        logic signed [18:0] quarter;
        logic signed [18:0] sum;
        logic signed [14:0] r;
        raw     = $signed({hi, lo});
        wide    = 19'(raw);
        quarter = (wide + (raw[15] ? 19'sd3 : 19'sd0)) >>> 2;
        sum     = (wide <<< 2) + (wide <<< 1) + quarter;
        if (sum > 19'sd16383) begin
            r = 15'sd16383;
        end else if (sum < -19'sd16384) begin
            r = -15'sd16384;
        end else begin
            r = sum[14:0];
        end
        return r;
    endfunction

    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // One bus tick of the sequencer.
    always_comb begin
        step_next  = step_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        rom_next   = rom_reg;
        temp_next  = temp_reg;
        last_next  = last_reg;
        drive      = 1'b0;
        done       = 1'b0;
        finish     = 1'b0;
        rom_again  = 1'b0;
        entered    = enter_step(step_reg, shift_reg);
        cur_entry  = owtm_pkg::prog_entry(step_reg);

        // A command is taken only while no sequence runs.
        if (step_reg == owtm_pkg::STEP_NONE && item.start_step != owtm_pkg::STEP_NONE) begin
            byte_next = '0;
            if (item.start_step == owtm_pkg::STEP_WRITE) begin
                shift_next = item.write_byte;
            end
            entered    = enter_step(item.start_step, shift_next);
            step_next  = entered.step;
            phase_next = entered.phase;
            shift_next = entered.shift;
            timer_next = '0;
            bit_next   = '0;
        end

        // Duration of the timed phase this tick.
        unique case (phase_next)
            PH_RST_LOW:  dur = cfg.reset_low_us;
            PH_RST_REL:  dur = cfg.reset_release_us;
            PH_RST_WAIT: dur = cfg.presence_wait_us;
            PH_WR_LEAD:  dur = cfg.write_lead_us;
            PH_WR_HOLD:  dur = cfg.write_slot_us;
            PH_RD_WAIT:  dur = cfg.read_sample_us;
            PH_RD_REC:   dur = cfg.read_recovery_us;
            default:     dur = cfg.reset_low_us;
        endcase
        timer_inc = timer_next + 1'b1;
        timer_hit = (timer_inc >= dur);

        unique case (phase_next)
            PH_RST_LOW: begin
                drive      = 1'b1;
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) phase_next = PH_RST_REL;
            end
            PH_RST_REL: begin
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) phase_next = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) phase_next = PH_RST_HIGH;
            end
            PH_RST_HIGH: begin
                finish = item.line_level;
            end
            PH_WR_LEAD: begin
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) phase_next = PH_WR_START;
            end
            PH_WR_START: begin
                drive      = 1'b1;
                timer_next = '0;
                phase_next = PH_WR_HOLD;
            end
            PH_WR_HOLD: begin
                drive      = !shift_next[0];
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) begin
                    shift_next = {1'b0, shift_next[7:1]};
                    bit_next   = bit_next + 1'b1;
                    phase_next = PH_WR_REC;
                end
            end
            PH_WR_REC: begin
                timer_next = '0;
                if (bit_next >= BYTE_BITS) begin
                    finish = 1'b1;
                end else begin
                    phase_next = PH_WR_START;
                end
            end
            PH_RD_START: begin
                drive      = 1'b1;
                timer_next = '0;
                phase_next = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) begin
                    shift_next = {item.line_level, shift_next[7:1]};
                    phase_next = PH_RD_REC;
                end
            end
            PH_RD_REC: begin
                timer_next = timer_hit ? '0 : timer_inc;
                if (timer_hit) begin
                    bit_next = bit_next + 1'b1;
                    if (bit_next >= BYTE_BITS) begin
                        finish = 1'b1;
                    end else begin
                        phase_next = PH_RD_START;
                    end
                end
            end
            default: begin
                step_next  = owtm_pkg::STEP_NONE;
                phase_next = PH_IDLE;
            end
        endcase

        // End of a primitive: store what was read; next id byte, next step or end.
        if (finish) begin
            cur_entry = owtm_pkg::prog_entry(step_next);
            if (cur_entry.kind == owtm_pkg::K_READ) begin
                last_next = shift_next;
                case (cur_entry.store)
                    owtm_pkg::S_LOW:  low_next = shift_next;
                    owtm_pkg::S_TEMP: temp_next = to_centi(low_next, shift_next);
                    owtm_pkg::S_ROM: begin
                        for (int i = 0; i < owtm_pkg::ROM_BYTES; i++) begin
                            if (byte_next == BW'(i)) begin
                                rom_next[i*8 +: 8] = shift_next;
                            end
                        end
                        if (byte_next != LAST_BYTE) begin
                            rom_again = 1'b1;
                        end
                    end
                    default: last_next = shift_next;
                endcase
            end
            if (rom_again) begin
                byte_next  = byte_next + 1'b1;
                entered    = enter_step(step_next, shift_next);
                step_next  = entered.step;
                phase_next = entered.phase;
                shift_next = entered.shift;
                timer_next = '0;
                bit_next   = '0;
            end else if (cur_entry.next == owtm_pkg::STEP_NONE) begin
                step_next  = owtm_pkg::STEP_NONE;
                phase_next = PH_IDLE;
                timer_next = '0;
                bit_next   = '0;
                done       = 1'b1;
            end else begin
                entered    = enter_step(cur_entry.next, shift_next);
                step_next  = entered.step;
                phase_next = entered.phase;
                shift_next = entered.shift;
                timer_next = '0;
                bit_next   = '0;
            end
        end
    end

    // Output register: a result waits here until taken; no new tick is worked.
    always_comb begin
        res_next                   = res_reg;
        res_valid_next             = res_valid_reg;
        if (item_pop) begin
            res_valid_next             = 1'b1;
            res_next.drive_low         = drive;
            res_next.busy_res          = (step_next != owtm_pkg::STEP_NONE);
            res_next.done_res          = done;
            res_next.read_byte         = last_next;
            res_next.temperature_centi = temp_next;
            res_next.rom_id            = rom_next;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= owtm_pkg::STEP_NONE;
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_reg       <= '0;
            byte_reg      <= '0;
            shift_reg     <= '0;
            low_reg       <= '0;
            rom_reg       <= '0;
            temp_reg      <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (item_pop) begin
                step_reg  <= step_next;
                phase_reg <= phase_next;
                timer_reg <= timer_next;
                bit_reg   <= bit_next;
                byte_reg  <= byte_next;
                shift_reg <= shift_next;
                low_reg   <= low_next;
                rom_reg   <= rom_next;
                temp_reg  <= temp_next;
                last_reg  <= last_next;
            end
        end
        res_reg <= res_next;
    end

    // The sequencer is idle exactly when no program step is active.
    a_idle_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == owtm_pkg::STEP_NONE) == (phase_reg == PH_IDLE))
        else $error("program step and slot phase disagree on idle");

    // A completing tick leaves the block not busy.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");

    // The bit counter stops at one byte.
    a_bit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= BYTE_BITS)
        else $error("bit counter past one byte");

    // Every popped tick leaves a result in the output register.
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |=> res_valid_reg)
        else $error("popped tick produced no result");

endmodule

`default_nettype wire

// ===== sv/one_wire_temperature_master.sv =====
// Channel   Direction  Ports              Contents
// s_        in         s_tdata, s_tuser   one microsecond tick: line level, command, byte
// m_        out        m_tdata            bus drive, status, last read byte, temperature, id
// apb       in         psel .. prdata     seven 10-bit slot timing registers
//
// One tick is accepted and one result delivered per clock cycle, sustained while
// m_ is not stalled. A tick passes through the front register, the queue and
// the sequencer output register between input and output transfer. The rate
// is set by the sequencer, which evaluates one bus tick per cycle.
// aresetn is synchronous and active low; it restores the default timings.
// A stall on m_ holds results in the output register; the queue and the
// front register absorb three more ticks before s_tready drops.
`default_nettype none

module one_wire_temperature_master (
    input  wire         aclk,
    input  wire         aresetn,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick input
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,  // [7:0] write_byte, [8] line_level, zero fill above
    input  wire  [2:0]  s_tuser,  // [2:0] op
    // Result output
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata   // [0] drive_low, [1] busy_res, [2] done_res,
                                  // [10:3] read_byte, [25:11] temperature_centi,
                                  // [89:26] rom_id, zero fill above
);

    owtm_pkg::cfg_t       cfg_reg, cfg_next;
    owtm_pkg::reg_idx_t   reg_idx;
    owtm_pkg::tick_item_t front_item, queue_item;
    owtm_pkg::result_t    result;
    logic                 front_valid, queue_ready, queue_valid, queue_pop;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = owtm_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_idx)
                owtm_pkg::REG_RESET_LOW:     cfg_next.reset_low_us     = pwdata[9:0];
                owtm_pkg::REG_RESET_RELEASE: cfg_next.reset_release_us = pwdata[9:0];
                owtm_pkg::REG_PRESENCE_WAIT: cfg_next.presence_wait_us = pwdata[9:0];
                owtm_pkg::REG_READ_SAMPLE:   cfg_next.read_sample_us   = pwdata[9:0];
                owtm_pkg::REG_READ_RECOVERY: cfg_next.read_recovery_us = pwdata[9:0];
                owtm_pkg::REG_WRITE_LEAD:    cfg_next.write_lead_us    = pwdata[9:0];
                owtm_pkg::REG_WRITE_SLOT:    cfg_next.write_slot_us    = pwdata[9:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            owtm_pkg::REG_RESET_LOW:     prdata = {22'd0, cfg_reg.reset_low_us};
            owtm_pkg::REG_RESET_RELEASE: prdata = {22'd0, cfg_reg.reset_release_us};
            owtm_pkg::REG_PRESENCE_WAIT: prdata = {22'd0, cfg_reg.presence_wait_us};
            owtm_pkg::REG_READ_SAMPLE:   prdata = {22'd0, cfg_reg.read_sample_us};
            owtm_pkg::REG_READ_RECOVERY: prdata = {22'd0, cfg_reg.read_recovery_us};
            owtm_pkg::REG_WRITE_LEAD:    prdata = {22'd0, cfg_reg.write_lead_us};
            owtm_pkg::REG_WRITE_SLOT:    prdata = {22'd0, cfg_reg.write_slot_us};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us     <= 10'd480;
            cfg_reg.reset_release_us <= 10'd60;
            cfg_reg.presence_wait_us <= 10'd10;
            cfg_reg.read_sample_us   <= 10'd8;
            cfg_reg.read_recovery_us <= 10'd60;
            cfg_reg.write_lead_us    <= 10'd16;
            cfg_reg.write_slot_us    <= 10'd40;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accepts ticks and classifies the command.
    owtm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_write_byte (s_tdata[7:0]),
        .in_line_level (s_tdata[8]),
        .item_valid    (front_valid),
        .item_ready    (queue_ready),
        .item          (front_item)
    );

    // Short queue between front end and sequencer.
    owtm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_valid),
        .push_item  (front_item),
        .push_ready (queue_ready),
        .pop        (queue_pop),
        .pop_valid  (queue_valid),
        .pop_item   (queue_item)
    );

    // Back end: bus sequencer and result register.
    owtm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    assign m_tdata = {6'd0, result};

endmodule

`default_nettype wire

// ===== sim/tb_one_wire_temperature_master.sv =====
`default_nettype none

module tb_one_wire_temperature_master;
    import owtm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BUDGET = 10;
    localparam int FAST_ROW = 1;

    // Command codes outside the defined set; the block must ignore them.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Program steps that read bytes from a specific position of the device data.
    localparam logic [STEP_W-1:0] STEP_TEMP_HIGH = STEP_TEMP + 4'd7;
    localparam logic [STEP_W-1:0] STEP_ID_BYTES  = STEP_ROM + 4'd2;

    typedef enum logic [3:0] {
        SLOT_IDLE, RST_LOW, RST_RELEASE, RST_WAIT, RST_SENSE,
        WR_LEAD, WR_START, WR_HOLD, WR_RECOVER,
        RD_START, RD_WAIT, RD_RECOVER
    } slot_t;

    typedef enum logic [1:0] {
        CHECK_NONE, CHECK_ZERO, CHECK_TEMP
    } check_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  wb;
        logic [63:0] device;
        logic [7:0]  hold_low;
        logic        busy_noise;
        check_t      check;
        logic [14:0] temp;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    // Predictor state of the bus sequencer.
    entry_t             seq_prog [15];
    logic [9:0]         timing [7];
    logic [STEP_W-1:0]  cur_step;
    slot_t              slot;
    logic [9:0]         tick_count;
    logic [3:0]         bit_count;
    logic [3:0]         byte_count;
    logic [7:0]         shift_byte;
    logic [7:0]         low_byte;
    logic [7:0]         last_byte;
    logic [63:0]        id_reg;
    logic [14:0]        temp_reg;

    // Emulated bus device and traffic shaping.
    logic [63:0] device_bytes;
    int          presence_low_left;
    bit          line_noise;
    bit          gaps_on;

    result_t     expected_results [$];
    dir_row_t    directed [17];
    int          errors = 0;
    int          cycle_count = 0;

    one_wire_temperature_master DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // [7:0] write_byte, [8] line_level, zero fill above
        .s_tuser  (s_tuser),  // [2:0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)   // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_byte,
                              // [25:11] temperature_centi, [89:26] rom_id, zero fill above
    );

    always #6 aclk = ~aclk;

    // Counts one tick of the current timed phase; true when the phase has run out.
    function automatic bit tick_elapsed(input logic [9:0] dur);
        tick_count = tick_count + 10'd1;
        if (tick_count >= dur) begin
            tick_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void enter_step(input logic [STEP_W-1:0] idx);
        cur_step = idx;
        tick_count = '0;
        bit_count = '0;
        case (seq_prog[idx].kind)
            K_RESET: slot = RST_LOW;
            K_WFIX: begin
                shift_byte = seq_prog[idx].data;
                slot = WR_LEAD;
            end
            K_WLATCH: slot = WR_LEAD;
            default: begin
                shift_byte = '0;
                slot = RD_START;
            end
        endcase
    endfunction

    // Raw reading times 6.25, truncated toward zero and clamped to 15 bits.
    function automatic logic [14:0] centi_degrees(input logic [7:0] lo, input logic [7:0] hi);
        int raw;
        int t;
        raw = int'($signed({hi, lo}));
        t = 6 * raw + raw / 4;
        if (t > 16383) t = 16383;
        if (t < -16384) t = -16384;
        return t[14:0];
    endfunction

    // Ends the current bus primitive; returns true when the whole command is done.
    function automatic bit close_step();
        entry_t e;
        e = seq_prog[cur_step];
        if (e.kind == K_READ) begin
            last_byte = shift_byte;
            case (e.store)
                S_LOW: low_byte = shift_byte;
                S_TEMP: temp_reg = centi_degrees(low_byte, shift_byte);
                S_ROM: begin
                    id_reg[8 * int'(byte_count[2:0]) +: 8] = shift_byte;
                    if (int'(byte_count) + 1 < ROM_BYTES) begin
                        byte_count = byte_count + 4'd1;
                        enter_step(cur_step);
                        return 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (e.next == STEP_NONE) begin
            cur_step = STEP_NONE;
            slot = SLOT_IDLE;
            tick_count = '0;
            bit_count = '0;
            return 1'b1;
        end
        enter_step(e.next);
        return 1'b0;
    endfunction

    // Advances the predicted sequencer by one microsecond tick.
    function automatic result_t model_tick(input logic [2:0] op, input logic [7:0] wb,
                                           input bit line);
        result_t r;
        bit drive;
        bit done;
        drive = 1'b0;
        done = 1'b0;
        if (cur_step == STEP_NONE && op >= OP_RESET && op <= OP_ROM) begin
            byte_count = '0;
            if (op == OP_WRITE) shift_byte = wb;
            case (op)
                OP_RESET: enter_step(STEP_RESET);
                OP_WRITE: enter_step(STEP_WRITE);
                OP_READ:  enter_step(STEP_READ);
                OP_TEMP:  enter_step(STEP_TEMP);
                default:  enter_step(STEP_ROM);
            endcase
        end
        case (slot)
            RST_LOW: begin
                drive = 1'b1;
                if (tick_elapsed(timing[REG_RESET_LOW])) slot = RST_RELEASE;
            end
            RST_RELEASE: if (tick_elapsed(timing[REG_RESET_RELEASE])) slot = RST_WAIT;
            RST_WAIT: if (tick_elapsed(timing[REG_PRESENCE_WAIT])) slot = RST_SENSE;
            RST_SENSE: if (line) done = close_step();
            WR_LEAD: if (tick_elapsed(timing[REG_WRITE_LEAD])) slot = WR_START;
            WR_START: begin
                drive = 1'b1;
                tick_count = '0;
                slot = WR_HOLD;
            end
            WR_HOLD: begin
                drive = ~shift_byte[0];
                if (tick_elapsed(timing[REG_WRITE_SLOT])) begin
                    shift_byte = shift_byte >> 1;
                    bit_count = bit_count + 4'd1;
                    slot = WR_RECOVER;
                end
            end
            WR_RECOVER: begin
                tick_count = '0;
                if (bit_count >= 4'd8) done = close_step();
                else slot = WR_START;
            end
            RD_START: begin
                drive = 1'b1;
                tick_count = '0;
                slot = RD_WAIT;
            end
            RD_WAIT: begin
                if (tick_elapsed(timing[REG_READ_SAMPLE])) begin
                    shift_byte = {line, shift_byte[7:1]};
                    slot = RD_RECOVER;
                end
            end
            RD_RECOVER: begin
                if (tick_elapsed(timing[REG_READ_RECOVERY])) begin
                    bit_count = bit_count + 4'd1;
                    if (bit_count >= 4'd8) done = close_step();
                    else slot = RD_START;
                end
            end
            default: begin
                cur_step = STEP_NONE;
                slot = SLOT_IDLE;
            end
        endcase
        r.drive_low = drive;
        r.busy_res = (cur_step != STEP_NONE);
        r.done_res = done;
        r.read_byte = last_byte;
        r.temperature_centi = temp_reg;
        r.rom_id = id_reg;
        return r;
    endfunction

    // Level the emulated device and pull-up put on the bus for the coming tick.
    function automatic bit bus_line();
        int k;
        case (slot)
            RST_SENSE: begin
                if (presence_low_left > 0) begin
                    presence_low_left--;
                    return 1'b0;
                end
                return !line_noise || $urandom_range(0, 3) != 0;
            end
            RD_WAIT: begin
                if (line_noise && $urandom_range(0, 15) == 0) return 1'($urandom_range(0, 1));
                if (cur_step == STEP_ID_BYTES) k = int'(byte_count);
                else if (cur_step == STEP_TEMP_HIGH) k = 1;
                else k = 0;
                return device_bytes[8 * k + int'(bit_count)];
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    endfunction

    // Offers one tick on s_ and records its expected result once it is taken.
    task automatic transfer_tick(input logic [2:0] op, input logic [7:0] wb, input bit line,
                                 input result_t want);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, line, wb};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(want);
    endtask

    // Issues one tick carrying op, then filler ticks (plain, or random ops with busy_noise) until the command finishes.
    task automatic run_command(input logic [2:0] op, input logic [7:0] wb,
                               input bit busy_noise, input check_t check,
                               input logic [14:0] temp);
        result_t want;
        logic [2:0] fill;
        bit line;
        line = bus_line();
        want = model_tick(op, wb, line);
        if (check == CHECK_ZERO) want = '0;
        if (check == CHECK_TEMP && want.done_res) want.temperature_centi = temp;
        transfer_tick(op, wb, line, want);
        while (cur_step != STEP_NONE) begin
            fill = busy_noise ? 3'($urandom_range(OP_RESET, OP_SPARE_HI)) : OP_TICK;
            wb = 8'($urandom);
            line = bus_line();
            want = model_tick(fill, wb, line);
            if (check == CHECK_TEMP && want.done_res) want.temperature_centi = temp;
            transfer_tick(fill, wb, line, want);
        end
    endtask

    // Mostly complete commands with random content, with stray and spare ops mixed in.
    task automatic random_phase(input int budget);
        int sent;
        int pick;
        logic [2:0] op;
        logic [7:0] wb;
        bit line;
        result_t want;
        sent = 0;
        while (sent < budget || cur_step != STEP_NONE) begin
            wb = 8'($urandom);
            if (cur_step == STEP_NONE) begin
                pick = $urandom_range(0, 15);
                if (pick < 2) begin
                    op = OP_TICK;
                end else if (pick == 2) begin
                    op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end else begin
                    op = 3'($urandom_range(OP_RESET, OP_ROM));
                    device_bytes = {$urandom, $urandom};
                    presence_low_left = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : 0;
                end
            end else begin
                op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(OP_RESET, OP_SPARE_HI))
                                                 : OP_TICK;
            end
            line = bus_line();
            want = model_tick(op, wb, line);
            transfer_tick(op, wb, line, want);
            sent++;
        end
    endtask

    // One APB transfer; a read is checked against the predicted register value.
    task automatic apb_access(input bit is_write, input reg_idx_t idx, input logic [9:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= {22'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (is_write) begin
            timing[idx] = val;
        end else if (prdata[9:0] !== timing[idx]) begin
            $display("%0t: register %0d readback mismatch: expected %h, got %h",
                     $time, idx, timing[idx], prdata[9:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_timings(input int lo, input int hi);
        for (int i = 0; i < 7; i++) begin
            apb_access(1'b1, reg_idx_t'(i), 10'($urandom_range(lo, hi)));
            apb_access(1'b0, reg_idx_t'(i), '0);
        end
    endtask

    // Stops offering ticks and lets every outstanding result arrive.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Result stall pattern: bursts of back-pressure of random length.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest prediction.
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[89:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transfer, got %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("drive_low", 64'(want.drive_low), 64'(got.drive_low));
                compare_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
                compare_field("done_res", 64'(want.done_res), 64'(got.done_res));
                compare_field("read_byte", 64'(want.read_byte), 64'(got.read_byte));
                compare_field("temperature_centi", 64'(15'(want.temperature_centi)),
                              64'(15'(got.temperature_centi)));
                compare_field("rom_id", want.rom_id, got.rom_id);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_TICK;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        line_noise = 1'b0;
        presence_low_left = 0;
        device_bytes = '0;

        // Sequence program: reset, write, read, then the temperature and id scripts.
        for (int i = 0; i < 15; i++) seq_prog[i] = '{K_RESET, 8'h00, S_NONE, STEP_NONE};
        seq_prog[STEP_WRITE] = '{K_WLATCH, 8'h00, S_NONE, STEP_NONE};
        seq_prog[STEP_READ] = '{K_READ, 8'h00, S_NONE, STEP_NONE};
        seq_prog[STEP_TEMP] = '{K_RESET, 8'h00, S_NONE, STEP_TEMP + 4'd1};
        seq_prog[STEP_TEMP + 4'd1] = '{K_WFIX, CMD_SKIP_ROM, S_NONE, STEP_TEMP + 4'd2};
        seq_prog[STEP_TEMP + 4'd2] = '{K_WFIX, CMD_CONVERT, S_NONE, STEP_TEMP + 4'd3};
        seq_prog[STEP_TEMP + 4'd3] = '{K_RESET, 8'h00, S_NONE, STEP_TEMP + 4'd4};
        seq_prog[STEP_TEMP + 4'd4] = '{K_WFIX, CMD_SKIP_ROM, S_NONE, STEP_TEMP + 4'd5};
        seq_prog[STEP_TEMP + 4'd5] = '{K_WFIX, CMD_READ_PAD, S_NONE, STEP_TEMP + 4'd6};
        seq_prog[STEP_TEMP + 4'd6] = '{K_READ, 8'h00, S_LOW, STEP_TEMP_HIGH};
        seq_prog[STEP_TEMP_HIGH] = '{K_READ, 8'h00, S_TEMP, STEP_NONE};
        seq_prog[STEP_ROM] = '{K_RESET, 8'h00, S_NONE, STEP_ROM + 4'd1};
        seq_prog[STEP_ROM + 4'd1] = '{K_WFIX, CMD_READ_ROM, S_NONE, STEP_ID_BYTES};
        seq_prog[STEP_ID_BYTES] = '{K_READ, 8'h00, S_ROM, STEP_NONE};

        // Predicted state after reset.
        timing[REG_RESET_LOW] = 10'd480;
        timing[REG_RESET_RELEASE] = 10'd60;
        timing[REG_PRESENCE_WAIT] = 10'd10;
        timing[REG_READ_SAMPLE] = 10'd8;
        timing[REG_READ_RECOVERY] = 10'd60;
        timing[REG_WRITE_LEAD] = 10'd16;
        timing[REG_WRITE_SLOT] = 10'd40;
        cur_step = STEP_NONE;
        slot = SLOT_IDLE;
        tick_count = '0;
        bit_count = '0;
        byte_count = '0;
        shift_byte = '0;
        low_byte = '0;
        last_byte = '0;
        id_reg = '0;
        temp_reg = '0;

        // Directed commands: op, byte, device data, presence hold, busy noise, check, expected temperature.
        directed = '{
            '{OP_TICK, 8'h00, 64'h0, 8'd0, 1'b0, CHECK_ZERO, 15'h0000},
            '{OP_RESET, 8'h00, 64'h0, 8'd3, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_RESET, 8'h00, 64'h0, 8'd25, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_WRITE, 8'h00, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_WRITE, 8'hff, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_WRITE, 8'ha5, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_READ, 8'h00, 64'h00, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_READ, 8'h00, 64'hff, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_TEMP, 8'h00, 64'h0000, 8'd0, 1'b0, CHECK_TEMP, 15'h0000},
            '{OP_TEMP, 8'h00, 64'h7fff, 8'd0, 1'b0, CHECK_TEMP, 15'h3fff},
            '{OP_TEMP, 8'h00, 64'h8000, 8'd0, 1'b0, CHECK_TEMP, 15'h4000},
            '{OP_TEMP, 8'h00, 64'hffff, 8'd0, 1'b0, CHECK_TEMP, 15'h7ffa},
            '{OP_ROM, 8'h00, 64'h0123_4567_89ab_cdef, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_SPARE_LO, 8'h00, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_SPARE_HI, 8'h00, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000},
            '{OP_READ, 8'h00, 64'h5a, 8'd0, 1'b1, CHECK_NONE, 15'h0000},
            '{OP_TICK, 8'h00, 64'h0, 8'd0, 1'b0, CHECK_NONE, 15'h0000}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Default timings must read back after reset.
        for (int i = 0; i < 7; i++) apb_access(1'b0, reg_idx_t'(i), '0);

        // Directed part: the first row at default timings, the rest with one-tick slots.
        for (int i = 0; i < 17; i++) begin
            if (i == FAST_ROW) begin
                wait_drained();
                program_timings(1, 1);
            end
            device_bytes = directed[i].device;
            presence_low_left = int'(directed[i].hold_low);
            run_command(directed[i].op, directed[i].wb, directed[i].busy_noise,
                        directed[i].check, directed[i].temp);
        end

        // Random part over several timing settings: minimum, zero, then small mixes.
        line_noise = 1'b1;
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            if (p == 0) program_timings(1, 1);
            else if (p == 1) program_timings(0, 0);
            else program_timings(0, 4);
            gaps_on = (p % 3 != 0);
            random_phase(RANDOM_BUDGET);
        end

        // Longest timings: every register takes and reads back its maximum value.
        wait_drained();
        program_timings(1023, 1023);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
